// ===== rtl/wctm_pkg.sv =====
`timescale 1ns / 1ps

package wctm_pkg;

    // Texture geometry: a square texture of TEX_SIZE x TEX_SIZE texels.
    localparam int TEX_BITS  = 6;
    localparam int TEX_SIZE  = 1 << TEX_BITS;
    localparam int TEX_AW    = 2 * TEX_BITS;
    localparam int TEX_DEPTH = 1 << TEX_AW;

    // Field widths.
    localparam int SH_W   = 11;
    localparam int LH_W   = 13;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 10;
    localparam int FRAC_W = 16;
    localparam int RGB_W  = 24;

    // Screen height limit and reset value.
    localparam int MAX_SCREEN_DIM = 1024;
    localparam logic [SH_W-1:0] SH_RESET = SH_W'(512);

    // Row arithmetic: texy = floor(d / (line_height * 256 / TEX_SIZE)).
    localparam int REM_W     = 21;
    localparam int SUM_W     = REM_W + 1;
    localparam int DIV_SHIFT = 8 - TEX_BITS;
    localparam int DIV_W     = LH_W + DIV_SHIFT;
    localparam int CMP_W     = DIV_W + TEX_BITS + 1;

    // Divider pipeline: one input stage, one saturation check, one stage per quotient bit.
    localparam int DIV_STAGES = TEX_BITS + 2;

    // Color halving mask for y-side walls.
    localparam logic [RGB_W-1:0] HALF_MASK = 24'h7F7F7F;

    // Operation codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SHADE = 1'b1;

    // One word as it travels through the pipeline.
    typedef struct packed {
        logic                is_pix;
        logic [TEX_AW-1:0]   tex_addr;
        logic [RGB_W-1:0]    texel;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic                side;
        logic [TEX_BITS-1:0] tcol;
        logic [REM_W-1:0]    rem;
        logic [DIV_W-1:0]    divisor;
        logic [TEX_BITS-1:0] quo;
        logic                sat;
    } t_item;

endpackage

// ===== rtl/wctm_row_div.sv =====
`timescale 1ns / 1ps

module wctm_row_div
    import wctm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic [DIV_STAGES-1:0] r_v;
    t_item                 r_st  [DIV_STAGES];
    t_item                 n_st  [DIV_STAGES];
    logic [DIV_STAGES:0]   stg_rdy;

    // A stage can load when it is empty or its word moves on.
    always_comb begin
        stg_rdy[DIV_STAGES] = i_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--) begin
            stg_rdy[s] = !r_v[s] || stg_rdy[s+1];
        end
    end

    // Restoring division, one quotient bit per stage after the saturation check.
    always_comb begin
        logic [CMP_W-1:0] rem_x;
        logic [CMP_W-1:0] shifted;
        int               k;
        n_st[0] = i_item;
        for (int s = 1; s < DIV_STAGES; s++) begin
            n_st[s] = r_st[s-1];
            rem_x   = CMP_W'(r_st[s-1].rem);
            if (s == 1) begin
                shifted     = CMP_W'(r_st[s-1].divisor) << TEX_BITS;
                n_st[s].sat = (rem_x >= shifted);
            end else begin
                k       = TEX_BITS + 1 - s;
                shifted = CMP_W'(r_st[s-1].divisor) << k;
                if (!r_st[s-1].sat && (rem_x >= shifted)) begin
                    n_st[s].rem    = REM_W'(rem_x - shifted);
                    n_st[s].quo[k] = 1'b1;
                end
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < DIV_STAGES; s++) begin
                if (stg_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (stg_rdy[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_item  = r_st[DIV_STAGES-1];

endmodule

// ===== rtl/wall_column_texture_mapper_top.sv =====
`timescale 1ns / 1ps
// Channel | Valid / Ready                 | Word
// in      | i_in_valid / o_in_ready       | i_func .. i_dir_y_neg (load or pixel)
// out     | o_out_valid / i_out_ready     | o_pix_col, o_pix_row, o_color
// cfg     | i_cfg_valid / o_cfg_ready     | i_cfg_screen_height
//
// One word is accepted per clock while the output is not stalled; the rate is set by the row divider pipeline,
// which resolves one quotient bit per stage, and the single texture RAM port.
// A pixel passes the divider stages, the texture RAM read register and the output register; loads give no word.
// Reset is synchronous and active low; screen_height returns to 512, texture RAM is kept.
// A stalled output only holds the stages that are full; bubbles ahead of it still fill.

module wall_column_texture_mapper_top
    import wctm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [TEX_AW-1:0] i_tex_addr,
    input  logic [RGB_W-1:0]  i_texel,
    input  logic [COL_W-1:0]  i_col,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [LH_W-1:0]   i_line_height,
    input  logic [FRAC_W-1:0] i_wall_frac,
    input  logic              i_side,
    input  logic              i_dir_x_pos,
    input  logic              i_dir_y_neg,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [COL_W-1:0]  o_pix_col,
    output logic [ROW_W-1:0]  o_pix_row,
    output logic [RGB_W-1:0]  o_color,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SH_W-1:0]   i_cfg_screen_height
);

    logic [SH_W-1:0]     r_screen_height;
    t_item               in_item;
    logic                div_valid;
    t_item               div_item;
    logic                m_en;
    logic                o_en;
    logic [TEX_BITS-1:0] row_idx;
    logic [TEX_AW-1:0]   mem_addr;

    logic [RGB_W-1:0]    mem [TEX_DEPTH];
    logic [RGB_W-1:0]    r_mem_q;
    logic                r_m_valid;
    logic [COL_W-1:0]    r_m_col;
    logic [ROW_W-1:0]    r_m_row;
    logic                r_m_side;

    logic                r_o_valid;
    logic [COL_W-1:0]    r_o_col;
    logic [ROW_W-1:0]    r_o_row;
    logic [RGB_W-1:0]    r_o_color;

    // Configuration register; writes are always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SH_RESET;
        end else if (i_cfg_valid) begin
            r_screen_height <= i_cfg_screen_height;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Prepare the word: texture column, row offset d and divisor.
    always_comb begin
        logic [SH_W-1:0]  h_eff;
        logic [LH_W-1:0]  lh_eff;
        logic [SUM_W-1:0] pos;
        logic [SUM_W-1:0] neg;
        logic             mirror;
        h_eff  = (r_screen_height > SH_W'(MAX_SCREEN_DIM)) ? SH_W'(MAX_SCREEN_DIM)
                                                           : r_screen_height;
        lh_eff = (i_line_height == '0) ? LH_W'(1) : i_line_height;
        pos    = (SUM_W'(i_row) << 8) + (SUM_W'(lh_eff) << 7);
        neg    = SUM_W'(h_eff) << 7;
        mirror = i_side ? i_dir_y_neg : i_dir_x_pos;

        in_item          = '0;
        in_item.is_pix   = (i_func == FUNC_SHADE);
        in_item.tex_addr = i_tex_addr;
        in_item.texel    = i_texel;
        in_item.col      = i_col;
        in_item.row      = i_row;
        in_item.side     = i_side;
        in_item.tcol     = mirror ? ~i_wall_frac[FRAC_W-1 -: TEX_BITS]
                                  :  i_wall_frac[FRAC_W-1 -: TEX_BITS];
        in_item.rem      = (pos > neg) ? REM_W'(pos - neg) : '0;
        in_item.divisor  = DIV_W'(lh_eff) << DIV_SHIFT;
    end

    wctm_row_div u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (div_valid),
        .i_ready (m_en),
        .o_item  (div_item)
    );

    // Stage enables toward the output.
    assign o_en = !r_o_valid || i_out_ready;
    assign m_en = !r_m_valid || o_en;

    // Texture address: saturated row and column for pixels, the load address otherwise.
    assign row_idx  = div_item.sat ? '1 : div_item.quo;
    assign mem_addr = div_item.is_pix ? {row_idx, div_item.tcol} : div_item.tex_addr;

    // Texture RAM: loads and pixel reads share one port in program order.
    always_ff @(posedge i_clk) begin
        if (div_valid && m_en) begin
            if (!div_item.is_pix) begin
                mem[mem_addr] <= div_item.texel;
            end else begin
                r_mem_q <= mem[mem_addr];
            end
        end
    end

    // Memory stage control and pixel data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_en) begin
            r_m_valid <= div_valid && div_item.is_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_en && div_valid && div_item.is_pix) begin
            r_m_col  <= div_item.col;
            r_m_row  <= div_item.row;
            r_m_side <= div_item.side;
        end
    end

    // Output register with shading for y-side walls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_en) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && r_m_valid) begin
            r_o_col   <= r_m_col;
            r_o_row   <= r_m_row;
            r_o_color <= r_m_side ? ((r_mem_q >> 1) & HALF_MASK) : r_mem_q;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_pix_col   = r_o_col;
    assign o_pix_row   = r_o_row;
    assign o_color     = r_o_color;

    // A pixel held in the memory stage keeps its texel while the output is blocked.
    a_mem_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !o_en |=> r_m_valid && $stable(r_mem_q))
        else $error("memory stage lost its texel under stall");

    // A taken result with nothing behind it leaves the output empty.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_out_ready && !r_m_valid |=> !r_o_valid)
        else $error("output word repeated");

    // Reset empties the output.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A configuration write lands in the register.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> r_screen_height == $past(i_cfg_screen_height))
        else $error("screen height write lost");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import wctm_pkg::*;

    localparam int SETTLE       = TEX_BITS + 8;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int STALL_CYCLES = 300;
    localparam int STALL_WORDS  = 40;
    localparam int RANDOM_WORDS = 800;
    localparam int MAX_PRINTS   = 30;

    // One input word as the sender offers it.
    typedef struct packed {
        logic              func;
        logic [TEX_AW-1:0] tex_addr;
        logic [RGB_W-1:0]  texel;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [LH_W-1:0]   line_height;
        logic [FRAC_W-1:0] wall_frac;
        logic              side;
        logic              dir_x_pos;
        logic              dir_y_neg;
    } t_in_word;

    // One shaded pixel as it should leave the block.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [RGB_W-1:0] color;
    } t_pixel;

    logic              i_clk               = 1'b0;
    logic              i_rst_n             = 1'b0;
    logic              i_in_valid          = 1'b0;
    logic              i_func              = FUNC_LOAD;
    logic [TEX_AW-1:0] i_tex_addr          = '0;
    logic [RGB_W-1:0]  i_texel             = '0;
    logic [COL_W-1:0]  i_col               = '0;
    logic [ROW_W-1:0]  i_row               = '0;
    logic [LH_W-1:0]   i_line_height       = '0;
    logic [FRAC_W-1:0] i_wall_frac         = '0;
    logic              i_side              = 1'b0;
    logic              i_dir_x_pos         = 1'b0;
    logic              i_dir_y_neg         = 1'b0;
    logic              i_out_ready         = 1'b0;
    logic              i_cfg_valid         = 1'b0;
    logic [SH_W-1:0]   i_cfg_screen_height = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [COL_W-1:0]  o_pix_col;
    logic [ROW_W-1:0]  o_pix_row;
    logic [RGB_W-1:0]  o_color;
    logic              o_cfg_ready;

    wall_column_texture_mapper_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_tex_addr          (i_tex_addr),
        .i_texel             (i_texel),
        .i_col               (i_col),
        .i_row               (i_row),
        .i_line_height       (i_line_height),
        .i_wall_frac         (i_wall_frac),
        .i_side              (i_side),
        .i_dir_x_pos         (i_dir_x_pos),
        .i_dir_y_neg         (i_dir_y_neg),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pix_col           (o_pix_col),
        .o_pix_row           (o_pix_row),
        .o_color             (o_color),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_screen_height (i_cfg_screen_height)
    );

    // Our own copy of the texture, which entries hold known data, and the height register.
    logic [RGB_W-1:0] texture_copy [TEX_DEPTH];
    bit               texel_loaded [TEX_DEPTH];
    logic [SH_W-1:0]  height_setting = SH_RESET;
    t_pixel           pending_pixels [$];

    int errors        = 0;
    int loads_done    = 0;
    int pixels_done   = 0;
    int words_sent    = 0;
    int heights_tried = 0;
    int cycles        = 0;
    bit tx_idle_en    = 1'b0;
    bit rx_idle_en    = 1'b0;
    int stall_kicks   = 0;
    int stall_served  = 0;
    int stall_left    = 0;
    int rx_wait       = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycle counter with a hard stop for a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Texture column: top bits of the hit fraction, mirrored for two face/direction cases.
    function automatic logic [TEX_BITS-1:0] texture_column(t_in_word w);
        longint t;
        t = (longint'(w.wall_frac) * TEX_SIZE) >> FRAC_W;
        if (t > TEX_SIZE - 1)
            t = TEX_SIZE - 1;
        if ((!w.side && w.dir_x_pos) || (w.side && w.dir_y_neg))
            t = TEX_SIZE - 1 - t;
        return t[TEX_BITS-1:0];
    endfunction

    // Texture row: scaled offset into the wall slice, clamped to the texture.
    function automatic logic [TEX_BITS-1:0] texture_row(t_in_word w);
        longint h;
        longint lh;
        longint d;
        longint q;
        h  = (height_setting > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : height_setting;
        lh = (w.line_height == 0) ? 1 : w.line_height;
        d  = longint'(w.row) * 256 - h * 128 + lh * 128;
        if (d <= 0)
            return '0;
        q = ((d * TEX_SIZE) / lh) / 256;
        if (q > TEX_SIZE - 1)
            q = TEX_SIZE - 1;
        return q[TEX_BITS-1:0];
    endfunction

    function automatic logic [TEX_AW-1:0] texel_index(t_in_word w);
        return {texture_row(w), texture_column(w)};
    endfunction

    // Short gaps mostly, a few long ones.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w.func        = 1'($urandom_range(0, 1));
        w.tex_addr    = TEX_AW'($urandom);
        w.texel       = RGB_W'($urandom);
        w.col         = COL_W'($urandom);
        w.row         = ROW_W'($urandom);
        w.line_height = LH_W'($urandom);
        w.wall_frac   = FRAC_W'($urandom);
        w.side        = 1'($urandom_range(0, 1));
        w.dir_x_pos   = 1'($urandom_range(0, 1));
        w.dir_y_neg   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_in_word make_pixel(int col, int row, int lh, int frac,
                                            bit side, bit xpos, bit yneg);
        t_in_word w;
        w             = random_word();
        w.func        = FUNC_SHADE;
        w.col         = COL_W'(col);
        w.row         = ROW_W'(row);
        w.line_height = LH_W'(lh);
        w.wall_frac   = FRAC_W'(frac);
        w.side        = side;
        w.dir_x_pos   = xpos;
        w.dir_y_neg   = yneg;
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
                     what, cycles, got, want);
    endtask

    // Offer one word, hold it until accepted, then update our copy of the block.
    task automatic send_word(t_in_word w);
        int     gap;
        t_pixel p;
        gap = (tx_idle_en && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= w.func;
        i_tex_addr    <= w.tex_addr;
        i_texel       <= w.texel;
        i_col         <= w.col;
        i_row         <= w.row;
        i_line_height <= w.line_height;
        i_wall_frac   <= w.wall_frac;
        i_side        <= w.side;
        i_dir_x_pos   <= w.dir_x_pos;
        i_dir_y_neg   <= w.dir_y_neg;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        words_sent++;
        if (w.func == FUNC_LOAD) begin
            texture_copy[w.tex_addr] = w.texel;
            texel_loaded[w.tex_addr] = 1'b1;
            loads_done++;
        end else begin
            p.col   = w.col;
            p.row   = w.row;
            p.color = texture_copy[texel_index(w)];
            if (w.side)
                p.color = (p.color >> 1) & HALF_MASK;
            pending_pixels.push_back(p);
            pixels_done++;
        end
    endtask

    // Shade one pixel; a texel it would read that holds nothing known is loaded first.
    task automatic shade_pixel(t_in_word w);
        t_in_word ld;
        w.func = FUNC_SHADE;
        if (!texel_loaded[texel_index(w)]) begin
            ld          = random_word();
            ld.func     = FUNC_LOAD;
            ld.tex_addr = texel_index(w);
            send_word(ld);
        end
        send_word(w);
    endtask

    // Stop offering, wait for every pixel, then let trailing loads clear the pipeline.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_height(logic [SH_W-1:0] value);
        i_cfg_valid         <= 1'b1;
        i_cfg_screen_height <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid    <= 1'b0;
        height_setting  = value;
        heights_tried++;
    endtask

    // One stretch of a wall column, stepping down the rows from somewhere in the slice.
    task automatic shade_wall_run();
        int       h;
        int       lh;
        int       top;
        int       bottom;
        int       r;
        int       n;
        int       pick;
        t_in_word w;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            lh = 0;
        else if (pick < 60)
            lh = $urandom_range(1, 600);
        else if (pick < 85)
            lh = $urandom_range(601, 2000);
        else
            lh = $urandom_range(2001, 8191);
        h      = (height_setting > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : height_setting;
        top    = h / 2 - lh / 2;
        bottom = h / 2 + lh / 2;
        if (top < 0)
            top = 0;
        if (top > 1023)
            top = 1023;
        if (bottom > 1023)
            bottom = 1023;
        if (bottom < top)
            bottom = top;
        r = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 1023) : $urandom_range(top, bottom);
        n = $urandom_range(1, 12);
        w = make_pixel($urandom_range(0, 1023), r, lh, $urandom_range(0, 65535),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        for (int k = 0; k < n && r <= 1023; k++) begin
            w.row = ROW_W'(r);
            shade_pixel(w);
            r++;
        end
    endtask

    // Receiver: check each pixel against the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel p;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected word", {o_pix_col, o_pix_row}, 0);
            end else begin
                p = pending_pixels.pop_front();
                if (o_pix_col !== p.col)
                    report_mismatch("pix_col", o_pix_col, p.col);
                if (o_pix_row !== p.row)
                    report_mismatch("pix_row", o_pix_row, p.row);
                if (o_color !== p.color)
                    report_mismatch("color", o_color, p.color);
            end
        end
    end

    // Long output hold-off, started on request and counted down here.
    always @(posedge i_clk) begin
        if (stall_kicks != stall_served) begin
            stall_served <= stall_kicks;
            stall_left   <= STALL_CYCLES;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Receiver ready with random stalls.
    always @(posedge i_clk) begin
        if (stall_left != 0 || stall_kicks != stall_served) begin
            i_out_ready <= 1'b0;
        end else if (rx_wait != 0) begin
            i_out_ready <= 1'b0;
            rx_wait     <= rx_wait - 1;
        end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
            i_out_ready <= 1'b0;
            rx_wait     <= idle_length() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Loads at the address and data extremes.
    task automatic test_texel_loads();
        t_in_word w;
        w          = random_word();
        w.func     = FUNC_LOAD;
        w.tex_addr = '0;
        w.texel    = '0;
        send_word(w);
        w.tex_addr = '1;
        w.texel    = '1;
        send_word(w);
        settle();
    endtask

    // Field extremes, slice clamping at both ends, and every face/direction case.
    task automatic test_pixel_extremes();
        shade_pixel(make_pixel(0, 0, 1, 16'h0000, 1'b0, 1'b0, 1'b0));
        shade_pixel(make_pixel(1023, 1023, 8191, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        shade_pixel(make_pixel(512, 256, 0, 16'h8000, 1'b1, 1'b0, 1'b0));
        shade_pixel(make_pixel(100, 0, 10, 16'h1234, 1'b0, 1'b1, 1'b1));
        shade_pixel(make_pixel(200, 1023, 10, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        shade_pixel(make_pixel(300, 256, 512, 16'h0000, 1'b1, 1'b0, 1'b1));
        for (int k = 0; k < 8; k++)
            shade_pixel(make_pixel($urandom_range(0, 1023), $urandom_range(200, 312), 128,
                                   $urandom_range(0, 65535), k[2], k[1], k[0]));
        settle();
    endtask

    // Height register at zero, one, the saturation edge and all ones.
    task automatic test_screen_heights();
        int values [5] = '{0, 1, MAX_SCREEN_DIM, MAX_SCREEN_DIM + 1, (1 << SH_W) - 1};
        foreach (values[k]) begin
            write_height(SH_W'(values[k]));
            shade_pixel(make_pixel($urandom_range(0, 1023), 0, 64,
                                   $urandom_range(0, 65535), 1'b0, 1'b1, 1'b0));
            shade_pixel(make_pixel($urandom_range(0, 1023), 600, 300,
                                   $urandom_range(0, 65535), 1'b1, 1'b0, 1'b1));
            settle();
        end
        write_height(SH_RESET);
    endtask

    // Output held off for a long stretch while words keep coming, so input stalls.
    task automatic test_output_stall();
        int start;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        stall_kicks++;
        start = words_sent;
        while (words_sent - start < STALL_WORDS)
            shade_wall_run();
        settle();
    endtask

    // Random wall columns mixed with stray loads, over several heights and idle patterns.
    task automatic test_random_columns();
        int       start;
        int       goal;
        t_in_word w;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_height(SH_W'($urandom_range(64, MAX_SCREEN_DIM)));
                1: write_height(SH_W'(MAX_SCREEN_DIM));
                2: write_height(SH_W'($urandom_range(MAX_SCREEN_DIM + 1, (1 << SH_W) - 1)));
                default: write_height(SH_W'($urandom_range(1, 200)));
            endcase
            tx_idle_en = (phase != 0);
            rx_idle_en = (phase != 0);
            start = words_sent;
            goal  = RANDOM_WORDS / 4;
            while (words_sent - start < goal) begin
                if ($urandom_range(0, 99) < 15) begin
                    w      = random_word();
                    w.func = FUNC_LOAD;
                    send_word(w);
                end else begin
                    shade_wall_run();
                end
            end
            settle();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_texel_loads();
        test_pixel_extremes();
        test_screen_heights();
        test_output_stall();
        test_random_columns();

        if (pending_pixels.size() != 0)
            report_mismatch("pixels never delivered", 0, pending_pixels.size());
        $display("Covered %0d texel loads and %0d shaded pixels over %0d height writes,",
                 loads_done, pixels_done, heights_tried);
        $display("with random idling on both sides and one %0d-cycle output hold-off.",
                 STALL_CYCLES);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
